>>> rtl/dewr_pkg.sv
// Shared types and constants for the double-ended queue with reverse.
// Used by dewr_ctrl and the top level double_ended_queue_with_reverse.
package dewr_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int VALUE_W        = 32;
  localparam int COUNT_W        = 5;

  typedef enum logic [1:0] {
    FUNC_INS_HEAD = 2'd0,
    FUNC_INS_TAIL = 2'd1,
    FUNC_REM_HEAD = 2'd2,
    FUNC_REVERSE  = 2'd3
  } func_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } ctrl_state_t;

  typedef struct packed {
    func_t                      func;
    logic signed [VALUE_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic                       ok;
    logic signed [VALUE_W-1:0]  removed_value;
    logic [COUNT_W-1:0]         count;
  } out_item_t;

endpackage

>>> rtl/dewr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dewr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/dewr_ctrl.sv
// Queue controller: ring pointers, count, direction flag and output register.
// Drives the slot RAM (dewr_ram); types from dewr_pkg.
module dewr_ctrl #(
  parameter int DEPTH      = dewr_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dewr_pkg::DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  dewr_pkg::in_item_t        in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output dewr_pkg::out_item_t       out_item,
  output logic                      ram_we,
  output logic [$clog2(DEPTH)-1:0]  ram_waddr,
  output logic [DATA_WIDTH-1:0]     ram_wdata,
  output logic [$clog2(DEPTH)-1:0]  ram_raddr,
  input  logic [DATA_WIDTH-1:0]     ram_rdata
);

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int HELD_W = $clog2(DEPTH + 1);
  localparam int SUM_W  = HELD_W + 1;

  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(DEPTH - 1);
  localparam logic [HELD_W-1:0] HELD_FULL = HELD_W'(DEPTH);

  dewr_pkg::ctrl_state_t state_r, state_nxt;
  logic [PTR_W-1:0]      front_r, front_nxt;
  logic [PTR_W-1:0]      back_r, back_nxt;
  logic [HELD_W-1:0]     held_r, held_nxt;
  logic                  rev_r, rev_nxt;
  logic                  out_valid_r, out_valid_nxt;
  dewr_pkg::out_item_t   out_item_r, out_item_nxt;

  logic             accept;
  logic             out_take;
  logic             at_front;
  logic [PTR_W-1:0] front_prev, front_next, back_prev, back_next;

  assign front_prev = (front_r == '0) ? PTR_LAST : front_r - PTR_W'(1);
  assign front_next = (front_r == PTR_LAST) ? '0 : front_r + PTR_W'(1);
  assign back_prev  = (back_r == '0) ? PTR_LAST : back_r - PTR_W'(1);
  assign back_next  = (back_r == PTR_LAST) ? '0 : back_r + PTR_W'(1);

  // Output register is free when empty or being drained this cycle.
  assign out_take = out_valid_r && !out_stall;
  assign in_stall = (state_r != dewr_pkg::ST_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign at_front = (in_item.func == dewr_pkg::FUNC_INS_HEAD) ^ rev_r;

  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    back_nxt      = back_r;
    held_nxt      = held_r;
    rev_nxt       = rev_r;
    out_valid_nxt = out_valid_r && !out_take;
    out_item_nxt  = out_item_r;
    ram_we        = 1'b0;
    ram_waddr     = back_r;
    ram_wdata     = DATA_WIDTH'($unsigned(in_item.value));
    ram_raddr     = front_r;

    case (state_r)
      dewr_pkg::ST_IDLE: begin
        if (accept) begin
          out_item_nxt.ok            = 1'b1;
          out_item_nxt.removed_value = '0;
          out_item_nxt.count         = dewr_pkg::COUNT_W'(held_r);
          case (in_item.func)
            dewr_pkg::FUNC_INS_HEAD, dewr_pkg::FUNC_INS_TAIL: begin
              out_valid_nxt = 1'b1;
              if (held_r == HELD_FULL) begin
                out_item_nxt.ok = 1'b0;
              end else begin
                ram_we   = 1'b1;
                held_nxt = held_r + HELD_W'(1);
                out_item_nxt.count = dewr_pkg::COUNT_W'(held_nxt);
                if (at_front) begin
                  ram_waddr = front_prev;
                  front_nxt = front_prev;
                end else begin
                  ram_waddr = back_r;
                  back_nxt  = back_next;
                end
              end
            end
            dewr_pkg::FUNC_REM_HEAD: begin
              if (held_r == '0) begin
                out_valid_nxt   = 1'b1;
                out_item_nxt.ok = 1'b0;
              end else begin
                // Slot data comes back next cycle; result is loaded in ST_READ.
                held_nxt  = held_r - HELD_W'(1);
                state_nxt = dewr_pkg::ST_READ;
                if (rev_r) begin
                  ram_raddr = back_prev;
                  back_nxt  = back_prev;
                end else begin
                  ram_raddr = front_r;
                  front_nxt = front_next;
                end
              end
            end
            default: begin
              rev_nxt       = !rev_r;
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      dewr_pkg::ST_READ: begin
        // No write can land in the read cycle: input is stalled here.
        state_nxt                  = dewr_pkg::ST_IDLE;
        out_valid_nxt              = 1'b1;
        out_item_nxt.ok            = 1'b1;
        out_item_nxt.removed_value = signed'(dewr_pkg::VALUE_W'(ram_rdata));
        out_item_nxt.count         = dewr_pkg::COUNT_W'(held_r);
      end
      default: begin
        state_nxt = dewr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dewr_pkg::ST_IDLE;
      front_r     <= '0;
      back_r      <= '0;
      held_r      <= '0;
      rev_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      held_r      <= held_nxt;
      rev_r       <= rev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // back pointer must sit held entries past front, modulo DEPTH
  logic [SUM_W-1:0] ring_sum;
  logic [PTR_W-1:0] back_expect;
  assign ring_sum    = SUM_W'(front_r) + SUM_W'(held_r);
  assign back_expect = (ring_sum >= SUM_W'(DEPTH)) ? PTR_W'(ring_sum - SUM_W'(DEPTH))
                                                   : PTR_W'(ring_sum);

  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= HELD_FULL)
    else $error("held count above depth");

  a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    back_r == back_expect)
    else $error("ring pointers disagree with held count");

  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dewr_pkg::ST_READ |-> !out_valid_r)
    else $error("output register busy when read data returns");

  a_remove_reads: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_item.func == dewr_pkg::FUNC_REM_HEAD && held_r != '0
    |=> state_r == dewr_pkg::ST_READ && out_valid_r == 1'b0)
    else $error("remove did not go through the read cycle");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(accept || state_r == dewr_pkg::ST_READ))
    else $error("result beat with no cause");

endmodule

>>> rtl/double_ended_queue_with_reverse.sv
// Top level of the double-ended queue with reverse: controller plus slot RAM.
// Depends on dewr_pkg, dewr_ctrl and dewr_ram.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------
//  in      | in_valid / in_stall  | in_item  (func, value)
//  out     | out_valid / out_stall| out_item (ok, removed_value, count)
//
// Inserts, reverse and failed removes load their result straight into the output register.
// A successful remove first passes through ST_READ for the registered slot RAM read.
// One item is in work at a time; the output register frees the input side.
// Synchronous active-low reset empties the queue; no RAM clearing pass.
// in_stall rises while a remove waits on RAM or a result beat is stalled.
module double_ended_queue_with_reverse #(
  parameter int DEPTH      = dewr_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dewr_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dewr_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output dewr_pkg::out_item_t out_item
);

  localparam int PTR_W = $clog2(DEPTH);

  logic                  ram_we;
  logic [PTR_W-1:0]      ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [PTR_W-1:0]      ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  dewr_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  dewr_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
